>>> rtl/qtt_pkg.sv
// Shared types, codes and character classes for the query text tokenizer.
package qtt_pkg;

    // Width of the positions carried in result words.
    localparam int TOKEN_POS_BITS = 16;

    // Default width of the running text position.
    localparam int POSITION_BITS_DEFAULT = 16;

    // Result queue depth; an end marker can push two words at once.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Token kinds, with a code for no pending token.
    typedef enum logic [3:0] {
        KIND_INVALID = 4'd0,
        KIND_LPAREN  = 4'd1,
        KIND_RPAREN  = 4'd2,
        KIND_EQUALS  = 4'd3,
        KIND_GLOB    = 4'd4,
        KIND_DGLOB   = 4'd5,
        KIND_COLON   = 4'd6,
        KIND_DCOLON  = 4'd7,
        KIND_AND     = 4'd8,
        KIND_OR      = 4'd9,
        KIND_LITERAL = 4'd10,
        KIND_REGEX   = 4'd11,
        KIND_END     = 4'd12,
        KIND_NONE    = 4'd15
    } kind_t;

    // Character codes.
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;

    // One result word.
    typedef struct packed {
        kind_t                      kind;
        logic [TOKEN_POS_BITS-1:0]  start_pos;
        logic [TOKEN_POS_BITS-1:0]  end_pos;
        logic                       last;
        logic                       overflow;
    } token_t;

    // Words produced by one processed item, in order.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    // Letters, digits and underscore continue a literal.
    function automatic logic is_word(input logic [7:0] c);
        is_word = (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                  (c >= CH_DIG_0 && c <= CH_DIG_9) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Kind of the token that a character opens.
    function automatic kind_t classify(input logic [7:0] c);
        kind_t k;
        if (c == CH_LPAREN)      k = KIND_LPAREN;
        else if (c == CH_RPAREN) k = KIND_RPAREN;
        else if (c == CH_EQUALS) k = KIND_EQUALS;
        else if (c == CH_STAR)   k = KIND_GLOB;
        else if (c == CH_COLON)  k = KIND_COLON;
        else if (c == CH_AMP)    k = KIND_AND;
        else if (c == CH_PIPE)   k = KIND_OR;
        else if (is_word(c))     k = KIND_LITERAL;
        else if (c == CH_SLASH)  k = KIND_REGEX;
        else                     k = KIND_INVALID;
        classify = k;
    endfunction

endpackage

>>> rtl/qtt_lexer.sv
// Input register, scanner state and the single-pass token logic.
module qtt_lexer
    import qtt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  char_code,
    input  logic        room,
    output push_t       push
);

    logic                      valid_reg, valid_next;
    logic                      action_reg;
    logic [7:0]                char_reg;
    kind_t                     pending_kind_reg, pending_kind_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  start_reg, start_next;
    logic                      rclosed_reg, rclosed_next;
    logic                      ovf_reg, ovf_next;
    logic                      fire;
    logic                      accept;
    logic                      absorbed;
    kind_t                     kind_mid;
    logic [TOKEN_POS_BITS-1:0] p_tok;
    logic [TOKEN_POS_BITS-1:0] s_tok;

    // The held word is processed once the result queue has room for two.
    assign fire     = valid_reg && room;
    assign in_stall = valid_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign p_tok    = TOKEN_POS_BITS'(pos_reg);
    assign s_tok    = TOKEN_POS_BITS'(start_reg);

    // Input register occupancy.
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    // Token logic for the held word.
    always_comb
    begin
        pending_kind_next = pending_kind_reg;
        pos_next          = pos_reg;
        start_next        = start_reg;
        rclosed_next      = rclosed_reg;
        ovf_next          = ovf_reg;
        absorbed          = 1'b0;
        kind_mid          = pending_kind_reg;
        push              = '0;
        push.first.kind   = KIND_END;
        push.second.kind  = KIND_END;

        if (fire)
        begin
            if (action_reg)
            begin
                // End marker closes any pending token, then END follows.
                if (pending_kind_reg != KIND_NONE)
                begin
                    push.count  = 2'd2;
                    push.first  = '{kind: pending_kind_reg, start_pos: s_tok, end_pos: p_tok,
                                    last: 1'b0, overflow: ovf_reg};
                    push.second = '{kind: KIND_END, start_pos: p_tok, end_pos: p_tok,
                                    last: 1'b1, overflow: ovf_reg};
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = '{kind: KIND_END, start_pos: p_tok, end_pos: p_tok,
                                   last: 1'b1, overflow: ovf_reg};
                end
                pending_kind_next = KIND_NONE;
                rclosed_next      = 1'b0;
            end
            else
            begin
                // Does the character extend the pending token?
                unique case (pending_kind_reg)
                    KIND_LITERAL:
                    begin
                        absorbed = is_word(char_reg);
                    end
                    KIND_REGEX:
                    begin
                        if (!rclosed_reg)
                        begin
                            absorbed = 1'b1;
                            if (char_reg == CH_SLASH)
                            begin
                                rclosed_next = 1'b1;
                            end
                        end
                    end
                    KIND_GLOB:
                    begin
                        if (char_reg == CH_STAR)
                        begin
                            kind_mid = KIND_DGLOB;
                            absorbed = 1'b1;
                        end
                    end
                    KIND_COLON:
                    begin
                        if (char_reg == CH_COLON)
                        begin
                            kind_mid = KIND_DCOLON;
                            absorbed = 1'b1;
                        end
                    end
                    default:
                    begin
                        absorbed = 1'b0;
                    end
                endcase
                pending_kind_next = kind_mid;

                // Position advances and saturates at its maximum.
                if (pos_reg == {POSITION_BITS{1'b1}})
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + {{(POSITION_BITS-1){1'b0}}, 1'b1};
                end

                // Emit the pending token and open the next one, unless the character is a space.
                if (!absorbed)
                begin
                    if (pending_kind_reg != KIND_NONE)
                    begin
                        push.count = 2'd1;
                        push.first = '{kind: pending_kind_reg, start_pos: s_tok,
                                       end_pos: p_tok, last: 1'b1, overflow: ovf_next};
                    end
                    if (is_space(char_reg))
                    begin
                        pending_kind_next = KIND_NONE;
                    end
                    else
                    begin
                        pending_kind_next = classify(char_reg);
                        start_next        = pos_reg;
                        rclosed_next      = 1'b0;
                    end
                end
            end
        end
    end

    // Control and scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= 1'b0;
            pending_kind_reg <= KIND_NONE;
            pos_reg          <= '0;
            start_reg        <= '0;
            rclosed_reg      <= 1'b0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            valid_reg        <= valid_next;
            pending_kind_reg <= pending_kind_next;
            pos_reg          <= pos_next;
            start_reg        <= start_next;
            rclosed_reg      <= rclosed_next;
            ovf_reg          <= ovf_next;
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            char_reg   <= char_code;
        end
    end

`ifndef ASSERT_OFF
    // An end marker always finishes with an END word.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && action_reg |-> (push.count == 2'd1 && push.first.kind == KIND_END) ||
                               (push.count == 2'd2 && push.second.kind == KIND_END))
        else $error("end marker did not finish with END");

    // Saturation is sticky until reset.
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    // A text character never yields more than one word.
    a_char_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !action_reg |-> push.count != 2'd2)
        else $error("text character produced two words");
`endif

endmodule

>>> rtl/qtt_result_fifo.sv
// Result queue that takes up to two words per cycle and sends one when out_stall is low.
module qtt_result_fifo
    import qtt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   room,
    output logic   out_valid,
    input  logic   out_stall,
    output token_t head
);

    token_t                    mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0]  wr_ptr_inc;
    logic [FIFO_CNT_BITS-1:0]  count_reg, count_next;
    logic                      pop;

    assign out_valid  = (count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign room       = (count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
    assign head       = mem[rd_ptr_reg];
    assign wr_ptr_inc = wr_ptr_reg + {{(FIFO_PTR_BITS-1){1'b0}}, 1'b1};

    // Pointer and occupancy update.
    always_comb
    begin
        rd_ptr_next = pop ? rd_ptr_reg + {{(FIFO_PTR_BITS-1){1'b0}}, 1'b1} : rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_BITS'(push.count);
        count_next  = count_reg + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.second;
        end
    end

`ifndef ASSERT_OFF
    // Words are pushed only when two entries are free.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH - 2))
        else $error("push without room");

    // Occupancy never passes the depth.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overrun");

    // A pop with no push lowers the count by one.
    a_count_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.count == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("count did not follow a pop");
`endif

endmodule

>>> rtl/query_text_tokenizer.sv
// Top level of the query text tokenizer: lexer and result queue.
// Path: an accepted word is held in the lexer input register, then goes to the result queue.
// Throughput: one text character per cycle while the queue has room; an end marker yields
// up to two words, the queue sends one per unstalled cycle, so end markers are paced by it.
// Reset: rst_n clears the scanner state (no pending token, position zero, overflow clear)
// and empties the result queue at once; there is no clearing pass.
module query_text_tokenizer
    import qtt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      action,
    input  logic [7:0]                char_code,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [3:0]                token_kind,
    output logic [TOKEN_POS_BITS-1:0] token_start,
    output logic [TOKEN_POS_BITS-1:0] token_end,
    output logic                      last_of_run,
    output logic                      position_overflow
);

    push_t  push;
    logic   room;
    token_t head;

    qtt_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .char_code (char_code),
        .room      (room),
        .push      (push)
    );

    qtt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Result word fields.
    assign token_kind        = head.kind;
    assign token_start       = head.start_pos;
    assign token_end         = head.end_pos;
    assign last_of_run       = head.last;
    assign position_overflow = head.overflow;

endmodule
